// ===== sv/fcau_pkg.sv =====
// ----------------------------------------------------------------------------
// fcau_pkg: shared types and constants
// Widths, command codes and the per-cell control word of the FIR correlator.
// ----------------------------------------------------------------------------
package fcau_pkg;

  localparam int MAX_TAPS = 16;
  localparam int TAP_W    = $clog2(MAX_TAPS);
  localparam int CNT_W    = $clog2(MAX_TAPS + 1);
  localparam int IDX_W    = 4;
  localparam int CFG_W    = 5;
  localparam int SMP_W    = 16;
  localparam int PROD_W   = 2 * SMP_W;
  localparam int ACC_W    = 40;
  localparam int GRP_N    = (MAX_TAPS + 3) / 4;
  localparam int GRP_W    = PROD_W + 2;
  localparam int TOT_W    = PROD_W + CNT_W;
  localparam int SUM_W    = ((TOT_W > ACC_W) ? TOT_W : ACC_W) + 1;

  localparam logic [CFG_W-1:0] TAP_COUNT_RESET = CFG_W'(16);

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef logic signed [PROD_W-1:0] prod_t;

  typedef struct packed {
    logic load;       // write coefficient
    logic insert;     // take the new sample
    logic take_next;  // take neighbor above (sample shift or rotate down)
    logic take_prev;  // take neighbor below (rotate up)
    logic active;     // tap in use
    logic adv;        // pipeline advance
  } cell_ctl_t;

endpackage

// ===== sv/fir_correlate_accumulate_unit.sv =====
// ----------------------------------------------------------------------------
// fir_correlate_accumulate_unit: FIR correlation onto a running sum
// Throughput: one word per cycle, load or sample, while in_ready is high. An
// accepted sample passes product, group sum, total and output registers.
// After a tap_count write, in_ready stays low while the circular delay line
// rotates one position per cycle to the new kernel length.
// Reset (rst, synchronous): coefficients zero, tap_count 16, pipeline empty.
// ----------------------------------------------------------------------------
module fir_correlate_accumulate_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [fcau_pkg::CFG_W-1:0]          cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [fcau_pkg::IDX_W-1:0]          tap_index,
  input  logic signed [fcau_pkg::SMP_W-1:0]   coefficient,
  input  logic signed [fcau_pkg::SMP_W-1:0]   sample,
  input  logic signed [fcau_pkg::ACC_W-1:0]   acc_in,
  input  logic                                block_start,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [fcau_pkg::ACC_W-1:0]   result
);

  localparam int M = fcau_pkg::MAX_TAPS;

  logic [fcau_pkg::CFG_W-1:0]        tap_count;
  logic [fcau_pkg::TAP_W-1:0]        tm1;
  logic [fcau_pkg::TAP_W-1:0]        tm1_next;
  logic [fcau_pkg::TAP_W-1:0]        tgt_m1;
  logic [fcau_pkg::CNT_W-1:0]        fill_count;
  logic [fcau_pkg::CNT_W-1:0]        fill_base;
  logic [fcau_pkg::CNT_W-1:0]        fill_next;
  logic                              aligned;
  logic                              rot_up;
  logic                              rot_dn;
  logic                              en;
  logic                              accept;
  logic                              smp;
  logic                              ld;
  logic                              emit;
  logic                              v1;
  logic signed [fcau_pkg::ACC_W-1:0] acc1;
  fcau_pkg::cell_ctl_t               ctl  [M];
  logic signed [fcau_pkg::SMP_W-1:0] taps [M];
  fcau_pkg::prod_t                   prods [M];

  // effective kernel length minus one
  always_comb begin
    if (tap_count == '0) begin
      tgt_m1 = '0;
    end else if (int'(tap_count) > M) begin
      tgt_m1 = fcau_pkg::TAP_W'(M - 1);
    end else begin
      tgt_m1 = fcau_pkg::TAP_W'(tap_count - fcau_pkg::CFG_W'(1));
    end
  end

  assign aligned  = (tm1 == tgt_m1);
  assign rot_up   = !aligned && (tm1 < tgt_m1);
  assign rot_dn   = !aligned && (tm1 > tgt_m1);
  assign en       = !out_valid || out_ready;
  assign in_ready = en && aligned;
  assign accept   = in_valid && in_ready;
  assign smp      = accept && (cmd == fcau_pkg::CMD_SAMPLE);
  assign ld       = accept && (cmd == fcau_pkg::CMD_LOAD);

  always_comb begin
    fill_base = block_start ? '0 : fill_count;
    fill_next = (int'(fill_base) < M) ? fill_base + fcau_pkg::CNT_W'(1) : fill_base;
    emit      = smp && (fill_next > fcau_pkg::CNT_W'(tm1));
  end

  always_comb begin
    if (rot_up) begin
      tm1_next = tm1 + fcau_pkg::TAP_W'(1);
    end else if (rot_dn) begin
      tm1_next = tm1 - fcau_pkg::TAP_W'(1);
    end else begin
      tm1_next = tm1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= fcau_pkg::TAP_COUNT_RESET;
      tm1        <= fcau_pkg::TAP_W'(M - 1);
      fill_count <= '0;
      v1         <= 1'b0;
    end else begin
      if (cfg_we) begin
        tap_count <= cfg_data;
      end
      tm1 <= tm1_next;
      if (smp) begin
        fill_count <= fill_next;
      end
      if (en) begin
        v1 <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc1 <= acc_in;
    end
  end

  // cell k holds the sample from ((tm1 - k) mod M) samples ago
  always_comb begin
    for (int k = 0; k < M; k++) begin
      ctl[k].load      = ld && (int'(tap_index) == k);
      ctl[k].insert    = smp && (tm1 == fcau_pkg::TAP_W'(k));
      ctl[k].take_next = (smp && (tm1 != fcau_pkg::TAP_W'(k))) || rot_dn;
      ctl[k].take_prev = rot_up;
      ctl[k].active    = (fcau_pkg::TAP_W'(k) <= tm1);
      ctl[k].adv       = en;
    end
  end

  for (genvar k = 0; k < M; k++) begin : g_cell
    fcau_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl[k]),
      .coef_in   (coefficient),
      .sample_in (sample),
      .from_next (taps[(k + 1) % M]),
      .from_prev (taps[(k + M - 1) % M]),
      .tap       (taps[k]),
      .product   (prods[k])
    );
  end

  fcau_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .v_in      (v1),
    .acc_in    (acc1),
    .prods     (prods),
    .out_valid (out_valid),
    .result    (result)
  );

  a_fill_bound : assert property (@(posedge clk) disable iff (rst)
    int'(fill_count) <= M)
    else $error("fill count above kernel size");

  a_load_no_result : assert property (@(posedge clk) disable iff (rst)
    ld |=> !v1)
    else $error("coefficient load produced a result");

  a_cfg_realign : assert property (@(posedge clk) disable iff (rst)
    cfg_we && !in_valid && !aligned |=> !in_ready)
    else $error("word accepted while delay line misaligned");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> !v1 || $stable(v1))
    else $error("product stage moved during output stall");

endmodule

// ===== sv/fcau_cell.sv =====
// ----------------------------------------------------------------------------
// fcau_cell: one tap of the correlator
// Holds one delay-line sample and one coefficient, hands its sample to its
// neighbors and registers the tap product.
// ----------------------------------------------------------------------------
module fcau_cell (
  input  logic                                  clk,
  input  logic                                  rst,
  input  fcau_pkg::cell_ctl_t                   ctl,
  input  logic signed [fcau_pkg::SMP_W-1:0]     coef_in,
  input  logic signed [fcau_pkg::SMP_W-1:0]     sample_in,
  input  logic signed [fcau_pkg::SMP_W-1:0]     from_next,
  input  logic signed [fcau_pkg::SMP_W-1:0]     from_prev,
  output logic signed [fcau_pkg::SMP_W-1:0]     tap,
  output fcau_pkg::prod_t                       product
);

  logic signed [fcau_pkg::SMP_W-1:0] coef;
  logic signed [fcau_pkg::SMP_W-1:0] tap_next;

  always_comb begin
    if (ctl.insert) begin
      tap_next = sample_in;
    end else if (ctl.take_next) begin
      tap_next = from_next;
    end else if (ctl.take_prev) begin
      tap_next = from_prev;
    end else begin
      tap_next = tap;
    end
  end

  always_ff @(posedge clk) begin
    tap <= tap_next;
    if (ctl.adv) begin
      product <= ctl.active ? fcau_pkg::prod_t'(coef) * fcau_pkg::prod_t'(tap_next) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (ctl.load) begin
      coef <= coef_in;
    end
  end

endmodule

// ===== sv/fcau_sum.sv =====
// ----------------------------------------------------------------------------
// fcau_sum: registered adder tree and saturation
// Sums the tap products in groups of four, adds the group sums and the
// accumulator input, and saturates to 40 bits into the output register.
// ----------------------------------------------------------------------------
module fcau_sum (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                v_in,
  input  logic signed [fcau_pkg::ACC_W-1:0]   acc_in,
  input  fcau_pkg::prod_t                     prods [fcau_pkg::MAX_TAPS],
  output logic                                out_valid,
  output logic signed [fcau_pkg::ACC_W-1:0]   result
);

  logic signed [fcau_pkg::GRP_W-1:0] grp      [fcau_pkg::GRP_N];
  logic signed [fcau_pkg::GRP_W-1:0] grp_next [fcau_pkg::GRP_N];
  logic signed [fcau_pkg::TOT_W-1:0] tot;
  logic signed [fcau_pkg::TOT_W-1:0] tot_next;
  logic signed [fcau_pkg::ACC_W-1:0] acc2;
  logic signed [fcau_pkg::ACC_W-1:0] acc3;
  logic signed [fcau_pkg::SUM_W-1:0] sum;
  logic signed [fcau_pkg::ACC_W-1:0] result_next;
  logic                              v2;
  logic                              v3;
  logic                              ovf;

  always_comb begin
    for (int g = 0; g < fcau_pkg::GRP_N; g++) begin
      grp_next[g] = '0;
      for (int i = 0; i < 4; i++) begin
        if (g * 4 + i < fcau_pkg::MAX_TAPS) begin
          grp_next[g] = grp_next[g] + fcau_pkg::GRP_W'(prods[g * 4 + i]);
        end
      end
    end
  end

  always_comb begin
    tot_next = '0;
    for (int g = 0; g < fcau_pkg::GRP_N; g++) begin
      tot_next = tot_next + fcau_pkg::TOT_W'(grp[g]);
    end
  end

  always_comb begin
    sum = fcau_pkg::SUM_W'(acc3) + fcau_pkg::SUM_W'(tot);
    ovf = (|sum[fcau_pkg::SUM_W-1:fcau_pkg::ACC_W-1])
        & ~(&sum[fcau_pkg::SUM_W-1:fcau_pkg::ACC_W-1]);
    if (ovf) begin
      result_next = sum[fcau_pkg::SUM_W-1] ? {1'b1, {(fcau_pkg::ACC_W-1){1'b0}}}
                                           : {1'b0, {(fcau_pkg::ACC_W-1){1'b1}}};
    end else begin
      result_next = sum[fcau_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grp    <= grp_next;
      acc2   <= acc_in;
      tot    <= tot_next;
      acc3   <= acc2;
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v2        <= v_in;
      v3        <= v2;
      out_valid <= v3;
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: testbench for fir_correlate_accumulate_unit
// Loads coefficients and streams sample blocks through the correlator over
// several kernel lengths and flow-control patterns. Every accepted word goes
// into a scoreboard that keeps its own coefficient store, delay line and fill
// count, predicts each windowed sum with saturation, and compares it in
// order with the results the block returns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int QUIET_LIMIT = 4000;
  localparam logic signed [fcau_pkg::ACC_W-1:0] ACC_MAX =
    {1'b0, {(fcau_pkg::ACC_W-1){1'b1}}};
  localparam logic signed [fcau_pkg::ACC_W-1:0] ACC_MIN =
    {1'b1, {(fcau_pkg::ACC_W-1){1'b0}}};

  class corr_scoreboard;
    logic signed [fcau_pkg::SMP_W-1:0] coeffs [fcau_pkg::MAX_TAPS];
    logic signed [fcau_pkg::SMP_W-1:0] window [fcau_pkg::MAX_TAPS];
    int fill;
    logic [fcau_pkg::CFG_W-1:0] taps;
    logic signed [fcau_pkg::ACC_W-1:0] expected_sums [$];
    int errors;

    function new();
      foreach (coeffs[i]) begin
        coeffs[i] = '0;
        window[i] = '0;
      end
      fill = 0;
      taps = fcau_pkg::TAP_COUNT_RESET;
      errors = 0;
    endfunction

    function int taps_used();
      if (taps == 0) return 1;
      if (taps > fcau_pkg::MAX_TAPS) return fcau_pkg::MAX_TAPS;
      return int'(taps);
    endfunction

    function void note_word(logic c, logic [fcau_pkg::IDX_W-1:0] idx,
                            logic signed [fcau_pkg::SMP_W-1:0] coef,
                            logic signed [fcau_pkg::SMP_W-1:0] smp,
                            logic signed [fcau_pkg::ACC_W-1:0] acc,
                            logic bs);
      int t;
      longint sum;
      longint sat_hi;
      longint sat_lo;
      sat_hi = (longint'(1) <<< (fcau_pkg::ACC_W - 1)) - 1;
      sat_lo = -(longint'(1) <<< (fcau_pkg::ACC_W - 1));
      if (c == fcau_pkg::CMD_LOAD) begin
        if (int'(idx) < fcau_pkg::MAX_TAPS) coeffs[idx] = coef;
        return;
      end
      if (bs) fill = 0;
      for (int k = fcau_pkg::MAX_TAPS - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = smp;
      if (fill < fcau_pkg::MAX_TAPS) fill++;
      t = taps_used();
      if (fill < t) return;
      sum = longint'(acc);
      for (int k = 0; k < t; k++)
        sum += longint'(coeffs[k]) * longint'(window[t-1-k]);
      if (sum > sat_hi) sum = sat_hi;
      if (sum < sat_lo) sum = sat_lo;
      expected_sums.push_back(sum[fcau_pkg::ACC_W-1:0]);
    endfunction

    function void check_result(logic signed [fcau_pkg::ACC_W-1:0] res);
      logic signed [fcau_pkg::ACC_W-1:0] exp_sum;
      if (expected_sums.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d", $time, res);
        errors++;
        return;
      end
      exp_sum = expected_sums.pop_front();
      if (res !== exp_sum) begin
        $display("%0t: result mismatch, expected %0d, got %0d", $time, exp_sum, res);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [fcau_pkg::CFG_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic cmd;
  logic [fcau_pkg::IDX_W-1:0] tap_index;
  logic signed [fcau_pkg::SMP_W-1:0] coefficient;
  logic signed [fcau_pkg::SMP_W-1:0] sample;
  logic signed [fcau_pkg::ACC_W-1:0] acc_in;
  logic block_start;
  logic out_valid;
  logic out_ready;
  logic signed [fcau_pkg::ACC_W-1:0] result;

  corr_scoreboard sb = new();
  int snd_idle_pct = 0;
  int rcv_stall_pct = 0;
  int quiet = 0;

  fir_correlate_accumulate_unit dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .cmd(cmd),
    .tap_index(tap_index),
    .coefficient(coefficient),
    .sample(sample),
    .acc_in(acc_in),
    .block_start(block_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.taps = cfg_data;
      if (in_valid && in_ready)
        sb.note_word(cmd, tap_index, coefficient, sample, acc_in, block_start);
      if (out_valid && out_ready) sb.check_result(result);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet + 1 >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic signed [fcau_pkg::SMP_W-1:0] rand_q15();
    case ($urandom_range(9))
      0: return -16'sd32768;
      1: return 16'sd32767;
      default: return fcau_pkg::SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [fcau_pkg::ACC_W-1:0] rand_acc();
    case ($urandom_range(9))
      0: return ACC_MAX;
      1: return ACC_MIN;
      2: return fcau_pkg::ACC_W'($signed($urandom_range(0, 1 << 31)) - (1 << 30));
      default: return fcau_pkg::ACC_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic send_word(logic c, logic [fcau_pkg::IDX_W-1:0] idx,
                           logic signed [fcau_pkg::SMP_W-1:0] coef,
                           logic signed [fcau_pkg::SMP_W-1:0] smp,
                           logic signed [fcau_pkg::ACC_W-1:0] acc,
                           logic bs);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    tap_index <= idx;
    coefficient <= coef;
    sample <= smp;
    acc_in <= acc;
    block_start <= bs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_load(logic [fcau_pkg::IDX_W-1:0] idx,
                           logic signed [fcau_pkg::SMP_W-1:0] coef);
    send_word(fcau_pkg::CMD_LOAD, idx, coef, rand_q15(), rand_acc(),
              1'($urandom_range(1)));
  endtask

  task automatic send_sample(logic signed [fcau_pkg::SMP_W-1:0] smp,
                             logic signed [fcau_pkg::ACC_W-1:0] acc,
                             logic bs);
    send_word(fcau_pkg::CMD_SAMPLE, fcau_pkg::IDX_W'($urandom_range(15)), rand_q15(),
              smp, acc, bs);
  endtask

  task automatic write_taps(logic [fcau_pkg::CFG_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // let the pipeline empty so the next tap_count write lands while idle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // mostly well-formed blocks with random content, some stray words
  task automatic run_random(int n_items);
    int sent;
    int blen;
    int r;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 12) begin
        send_load(fcau_pkg::IDX_W'($urandom_range(15)), rand_q15());
        sent++;
      end else if (r < 20) begin
        send_sample(rand_q15(), rand_acc(), 1'($urandom_range(1)));
        sent++;
      end else begin
        blen = $urandom_range(1, sb.taps_used() + 8);
        for (int k = 0; k < blen; k++) begin
          if ($urandom_range(9) == 0) begin
            send_load(fcau_pkg::IDX_W'($urandom_range(15)), rand_q15());
            sent++;
          end
          send_sample(rand_q15(), rand_acc(), k == 0);
          sent++;
        end
      end
    end
  endtask

  initial begin
    logic [fcau_pkg::CFG_W-1:0] tap_plan [8];
    tap_plan = '{5'd0, 5'd31, 5'd1, 5'd16, 5'd17, 5'd3, 5'd12, 5'd9};
    tap_plan[6] = fcau_pkg::CFG_W'($urandom_range(2, 15));
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    cmd <= fcau_pkg::CMD_LOAD;
    tap_index <= '0;
    coefficient <= '0;
    sample <= '0;
    acc_in <= '0;
    block_start <= 1'b0;
    out_ready <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: alternating full-scale kernel, saturation both ways, restart
    write_taps(5'd4);
    for (int i = 0; i < fcau_pkg::MAX_TAPS; i++)
      send_load(fcau_pkg::IDX_W'(i), (i % 2 == 0) ? 16'sd32767 : -16'sd32768);
    send_sample(-16'sd32768, '0, 1'b1);
    send_sample(16'sd32767, ACC_MAX, 1'b0);
    send_sample(-16'sd32768, ACC_MIN, 1'b0);
    send_sample(16'sd32767, ACC_MIN, 1'b0);
    send_sample(-16'sd32768, ACC_MAX, 1'b0);
    send_sample(16'sd0, '0, 1'b0);
    send_sample(16'sd1, ACC_MAX, 1'b1);
    send_sample(-16'sd1, ACC_MIN, 1'b0);
    send_sample(16'sd32767, '0, 1'b0);
    send_sample(-16'sd32768, -40'sd1, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct = 45;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct = 0;
          rcv_stall_pct = 45;
        end
        default: begin
          snd_idle_pct = 30;
          rcv_stall_pct = 30;
        end
      endcase
      write_taps(tap_plan[p]);
      run_random(116);
      drain();
    end

    if (sb.expected_sums.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.expected_sums.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/fcau_pkg.sv
sv/fcau_cell.sv
sv/fcau_sum.sv
sv/fir_correlate_accumulate_unit.sv
dv/tb_top.sv
